[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define XPFEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("xpfec assertion failed");

// Check that a condition never holds outside reset.
`define XPFEC_NEVER(lbl, cond) \
  `XPFEC_ASSERT(lbl, !(cond))

`endif

[rtl/xpfec_pkg.sv]
// ----------------------------------------------------------------------------
// xpfec_pkg
// Types and constants of the XOR parity FEC generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xpfec_pkg;

  // default geometry
  localparam int STORE_BYTES_DEF = 2048;
  localparam int MASK_SPAN_DEF   = 24;

  // fixed field widths
  localparam int GS_W       = 5;
  localparam int LEN_W      = 12;
  localparam int SEQ_W      = 16;
  localparam int OUT_MASK_W = 24;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 128;

  // group size limit: writes at or above it are ignored
  localparam logic [GS_W-1:0] GROUP_LIMIT = 5'd24;

  // sequence number step of the parity stream
  localparam logic [SEQ_W-1:0] SEQ_STEP = 16'h0001;

  // input item kinds (tuser)
  localparam logic OP_MEDIA = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // result kinds (tuser)
  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // result queue
  localparam int RES_DEPTH = 3;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 2;

  // XORed header fields of the protected packets
  typedef struct packed {
    logic             p;
    logic             x;
    logic [3:0]       cc;
    logic             m;
    logic [6:0]       pt;
    logic [31:0]      ts;
    logic [LEN_W-1:0] len;
  } hdr_t;

  // one result word
  typedef struct packed {
    logic                  kind;
    logic                  last;
    logic [SEQ_W-1:0]      fec_seq;
    logic [SEQ_W-1:0]      sn_base;
    logic [OUT_MASK_W-1:0] offset_mask;
    hdr_t                  hdr;
    logic [7:0]            pbyte;
  } res_t;

  // what the store stage does with a word
  typedef struct packed {
    logic res;      // push a result
    logic wr;       // write the store
    logic clr;      // write zero instead of the XOR
    logic use_ram;  // result byte comes from the store
  } p1_ctl_t;

endpackage

`default_nettype wire

[rtl/xpfec_ram.sv]
// ----------------------------------------------------------------------------
// xpfec_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module xpfec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/xor_parity_fec_generator.sv]
// ----------------------------------------------------------------------------
// xor_parity_fec_generator
// XOR parity FEC generator: builds one protection block per packet group.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-----------------------------
//  s_axis    | in  | s_axis_tvalid_i/s_axis_tready_o| tdata, tlast=byte_last, tuser=op
//  m_axis    | out | m_axis_tvalid_o/m_axis_tready_i| tdata, tlast=protect_last,
//            |     |                               | tuser=kind
//  cfg       | in  | cfg_wr_en_i                   | cfg_wr_data_i = group_size
//
//  One word is taken every cycle while s_axis_tready_o is high. Its result, if any,
//  passes the header logic and is registered with the store read in the store stage,
//  then is XORed and written back through the store's single write port as it is
//  pushed into the output queue. After reset the store is swept to zero, one byte
//  a cycle, over all STORE_BYTES addresses; s_axis_tready_o is low until it ends.
//  A three-word result queue parts the two sides; outside the sweep, ready drops
//  only when the queue plus the word in flight would fill it.
//
`default_nettype none

module xor_parity_fec_generator #(
  parameter int STORE_BYTES = xpfec_pkg::STORE_BYTES_DEF,
  parameter int MASK_SPAN   = xpfec_pkg::MASK_SPAN_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  // group size register
  input  wire logic                               cfg_wr_en_i,
  input  wire logic [xpfec_pkg::GS_W-1:0]         cfg_wr_data_i,

  // media bytes and read requests
  input  wire logic                               s_axis_tvalid_i,
  output      logic                               s_axis_tready_o,
  // tdata from bit 0: data_byte[8], seq_num[16], media_timestamp[32],
  // padding_bit, extension_bit, csrc_count[4], marker_bit, payload_type[7],
  // length_sum[12], zero fill[6]
  input  wire logic [xpfec_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  wire logic                               s_axis_tlast_i,   // byte_last
  input  wire logic                               s_axis_tuser_i,   // op

  // parity headers and protection bytes
  output      logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata from bit 0: fec_seq[16], sn_base[16], offset_mask[24],
  // flags_recovery[6], marker_pt_recovery[8], ts_recovery[32],
  // length_recovery[16], protect_byte[8], zero fill[2]
  output      logic [xpfec_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output      logic                               m_axis_tlast_o,   // protect_last
  output      logic                               m_axis_tuser_o    // kind
);

  // store address and byte count widths
  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = $clog2(STORE_BYTES + 1);
  localparam int CW = (LW > xpfec_pkg::LEN_W) ? LW : xpfec_pkg::LEN_W;
  localparam logic [LW-1:0] STORE_LEN = LW'(STORE_BYTES);

  // --------------------------------------------------------------------------
  // Input word fields
  // --------------------------------------------------------------------------
  logic                              in_acc;
  logic [7:0]                        in_byte;
  logic [xpfec_pkg::SEQ_W-1:0]       in_seq;
  logic [xpfec_pkg::LEN_W-1:0]       in_len;
  xpfec_pkg::hdr_t                   in_hdr;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign in_byte = s_axis_tdata_i[7:0];
  assign in_seq  = s_axis_tdata_i[23:8];
  assign in_len  = s_axis_tdata_i[81:70];

  // header bits of this packet as they enter the XOR
  assign in_hdr.ts  = s_axis_tdata_i[55:24];
  assign in_hdr.p   = s_axis_tdata_i[56];
  assign in_hdr.x   = s_axis_tdata_i[57];
  assign in_hdr.cc  = s_axis_tdata_i[61:58];
  assign in_hdr.m   = s_axis_tdata_i[62];
  assign in_hdr.pt  = s_axis_tdata_i[69:63];
  assign in_hdr.len = in_len;

  // --------------------------------------------------------------------------
  // Group state
  // --------------------------------------------------------------------------
  logic [xpfec_pkg::GS_W-1:0]  group_size_q;
  logic [xpfec_pkg::GS_W-1:0]  group_count_q, group_count_d;
  logic [xpfec_pkg::SEQ_W-1:0] base_seq_q,    base_seq_d;
  logic [MASK_SPAN-1:0]        group_mask_q,  group_mask_d;
  xpfec_pkg::hdr_t             hdr_xor_q,     hdr_xor_d;
  logic [LW-1:0]               largest_q,     largest_d;
  logic [LW-1:0]               byte_idx_q,    byte_idx_d;
  logic [xpfec_pkg::SEQ_W-1:0] parity_seq_q,  parity_seq_d;
  logic                        draining_q,    draining_d;
  logic                        pkt_active_q,  pkt_active_d;
  logic                        pkt_sel_q,     pkt_sel_d;

  // store sweep after reset
  logic                        clr_busy_q;
  logic [AW-1:0]               clr_addr_q;

  // store stage: one word on its way to the result queue
  logic                        p1_valid_q,    p1_valid_d;
  xpfec_pkg::p1_ctl_t          p1_ctl_q,      p1_ctl_d;
  logic [AW-1:0]               p1_addr_q,     p1_addr_d;
  logic [7:0]                  p1_data_q;
  xpfec_pkg::res_t             p1_res_q,      p1_res_d;

  // last store write, for a read that missed it
  logic                        fwd_valid_q;
  logic [AW-1:0]               fwd_addr_q;
  logic [7:0]                  fwd_data_q;

  // per-word working values
  logic                        pkt_first;
  logic                        grp_open;
  logic [xpfec_pkg::SEQ_W-1:0] base_eff;
  logic [MASK_SPAN-1:0]        mask_eff;
  xpfec_pkg::hdr_t             hdr_eff;
  logic [xpfec_pkg::SEQ_W-1:0] seq_diff;
  logic [MASK_SPAN-1:0]        diff_onehot;
  logic                        sel_eff;
  logic [LW-1:0]               idx_eff;
  logic [LW-1:0]               idx_inc;
  logic [CW-1:0]               len_ext;
  logic [LW-1:0]               len_cap;
  logic [LW-1:0]               largest_tmp;
  logic [xpfec_pkg::GS_W-1:0]  count_inc;
  logic [LW-1:0]               drain_inc;
  logic                        drain_last;
  logic                        drain_in_store;
  logic [AW-1:0]               ram_raddr;

  // A packet's first byte opens a new group when none is counted yet.
  assign pkt_first = ~pkt_active_q;
  assign grp_open  = pkt_first & (group_count_q == '0);
  assign base_eff  = grp_open ? in_seq : base_seq_q;
  assign mask_eff  = grp_open ? '0 : group_mask_q;
  assign hdr_eff   = grp_open ? '0 : hdr_xor_q;
  assign seq_diff  = in_seq - base_eff;
  assign sel_eff   = pkt_first ? (seq_diff < xpfec_pkg::SEQ_W'(MASK_SPAN)) : pkt_sel_q;
  assign idx_eff   = pkt_first ? '0 : byte_idx_q;
  assign idx_inc   = idx_eff + LW'(1);
  assign count_inc = group_count_q + xpfec_pkg::GS_W'(1);

  // Cap the signalled length at the store size.
  assign len_ext = CW'(in_len);
  assign len_cap = (len_ext > CW'(STORE_BYTES)) ? STORE_LEN : LW'(len_ext);

  always_comb begin
    for (int i = 0; i < MASK_SPAN; i++) begin
      diff_onehot[i] = (seq_diff == xpfec_pkg::SEQ_W'(i));
    end
  end

  // Drain step: one protection byte per read word.
  assign drain_in_store = byte_idx_q < STORE_LEN;
  assign drain_inc      = byte_idx_q + LW'(1);
  assign drain_last     = drain_inc >= largest_q;

  // Read the byte this word touches; the data arrives with the store stage.
  assign ram_raddr = (s_axis_tuser_i == xpfec_pkg::OP_READ) ? byte_idx_q[AW-1:0]
                                                            : idx_eff[AW-1:0];

  always_comb begin
    group_count_d = group_count_q;
    base_seq_d    = base_seq_q;
    group_mask_d  = group_mask_q;
    hdr_xor_d     = hdr_xor_q;
    largest_d     = largest_q;
    byte_idx_d    = byte_idx_q;
    parity_seq_d  = parity_seq_q;
    draining_d    = draining_q;
    pkt_active_d  = pkt_active_q;
    pkt_sel_d     = pkt_sel_q;
    largest_tmp   = largest_q;
    p1_valid_d    = 1'b0;
    p1_ctl_d      = '0;
    p1_addr_d     = ram_raddr;
    p1_res_d      = '0;

    if (in_acc) begin
      if (s_axis_tuser_i == xpfec_pkg::OP_READ) begin
        // read words only count while a block is pending
        if (draining_q) begin
          p1_valid_d       = 1'b1;
          p1_ctl_d.res     = 1'b1;
          p1_ctl_d.wr      = drain_in_store;
          p1_ctl_d.clr     = 1'b1;
          p1_ctl_d.use_ram = drain_in_store;
          p1_res_d.kind    = xpfec_pkg::KIND_BYTE;
          p1_res_d.last    = drain_last;
          if (drain_last) begin
            draining_d = 1'b0;
            largest_d  = '0;
            byte_idx_d = '0;
          end else begin
            byte_idx_d = drain_inc;
          end
        end
      end else if (!draining_q && (group_size_q != '0)) begin
        base_seq_d   = base_eff;
        group_mask_d = mask_eff;
        hdr_xor_d    = hdr_eff;
        pkt_active_d = 1'b1;
        pkt_sel_d    = sel_eff;
        byte_idx_d   = idx_eff;

        // fold the header of a selected packet in on its first byte
        if (pkt_first && sel_eff) begin
          group_mask_d = mask_eff | diff_onehot;
          hdr_xor_d    = hdr_eff ^ in_hdr;
          if (len_cap > largest_tmp) begin
            largest_tmp = len_cap;
          end
        end

        // bytes beyond the store are counted nowhere
        if (idx_eff < STORE_LEN) begin
          if (sel_eff) begin
            p1_valid_d  = 1'b1;
            p1_ctl_d.wr = 1'b1;
            if (idx_inc > largest_tmp) begin
              largest_tmp = idx_inc;
            end
          end
          byte_idx_d = idx_inc;
        end
        largest_d = largest_tmp;

        if (s_axis_tlast_i) begin
          pkt_active_d  = 1'b0;
          pkt_sel_d     = 1'b0;
          byte_idx_d    = '0;
          group_count_d = count_inc;
          // close the group: emit its header and start draining unless its largest length is zero
          if (count_inc >= group_size_q) begin
            p1_valid_d           = 1'b1;
            p1_ctl_d.res         = 1'b1;
            p1_res_d.kind        = xpfec_pkg::KIND_HDR;
            p1_res_d.fec_seq     = parity_seq_q;
            p1_res_d.sn_base     = base_eff;
            p1_res_d.offset_mask = xpfec_pkg::OUT_MASK_W'(group_mask_d);
            p1_res_d.hdr         = hdr_xor_d;
            parity_seq_d         = parity_seq_q + xpfec_pkg::SEQ_STEP;
            group_count_d        = '0;
            group_mask_d         = '0;
            hdr_xor_d            = '0;
            draining_d           = (largest_tmp != '0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q  <= '0;
      group_count_q <= '0;
      base_seq_q    <= '0;
      group_mask_q  <= '0;
      hdr_xor_q     <= '0;
      largest_q     <= '0;
      byte_idx_q    <= '0;
      parity_seq_q  <= '0;
      draining_q    <= 1'b0;
      pkt_active_q  <= 1'b0;
      pkt_sel_q     <= 1'b0;
      p1_valid_q    <= 1'b0;
      p1_ctl_q      <= '0;
      fwd_valid_q   <= 1'b0;
      clr_busy_q    <= 1'b1;
      clr_addr_q    <= '0;
    end else begin
      // drop out-of-range group sizes
      if (cfg_wr_en_i && (cfg_wr_data_i < xpfec_pkg::GROUP_LIMIT)) begin
        group_size_q <= cfg_wr_data_i;
      end
      group_count_q <= group_count_d;
      base_seq_q    <= base_seq_d;
      group_mask_q  <= group_mask_d;
      hdr_xor_q     <= hdr_xor_d;
      largest_q     <= largest_d;
      byte_idx_q    <= byte_idx_d;
      parity_seq_q  <= parity_seq_d;
      draining_q    <= draining_d;
      pkt_active_q  <= pkt_active_d;
      pkt_sel_q     <= pkt_sel_d;
      p1_valid_q    <= p1_valid_d;
      p1_ctl_q      <= p1_ctl_d;
      fwd_valid_q   <= p1_valid_q & p1_ctl_q.wr;
      if (clr_busy_q) begin
        if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
          clr_busy_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Protection store and XOR write-back
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [7:0]    old_byte;
  logic          p1_push;
  xpfec_pkg::res_t push_res;

  // The store reads before it writes: take the previous write if it hit us.
  assign old_byte = (fwd_valid_q && (fwd_addr_q == p1_addr_q)) ? fwd_data_q : ram_rdata;

  assign ram_we    = clr_busy_q | (p1_valid_q & p1_ctl_q.wr);
  assign ram_waddr = clr_busy_q ? clr_addr_q : p1_addr_q;
  assign ram_wdata = (clr_busy_q || p1_ctl_q.clr) ? 8'h00 : (old_byte ^ p1_data_q);

  xpfec_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    p1_addr_q  <= p1_addr_d;
    p1_data_q  <= in_byte;
    p1_res_q   <= p1_res_d;
    fwd_addr_q <= p1_addr_q;
    fwd_data_q <= ram_wdata;
  end

  assign p1_push = p1_valid_q & p1_ctl_q.res;

  always_comb begin
    push_res       = p1_res_q;
    push_res.pbyte = p1_ctl_q.use_ram ? old_byte : 8'h00;
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  xpfec_pkg::res_t                 res_fifo_q [xpfec_pkg::RES_DEPTH];
  logic [xpfec_pkg::RES_PTR_W-1:0] res_wr_ptr_q;
  logic [xpfec_pkg::RES_PTR_W-1:0] res_rd_ptr_q;
  logic [xpfec_pkg::RES_CNT_W-1:0] res_cnt_q;
  logic                            res_pop;
  xpfec_pkg::res_t                 res_head;

  assign res_pop  = (res_cnt_q != '0) & m_axis_tready_i;
  assign res_head = res_fifo_q[res_rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (p1_push) begin
      res_fifo_q[res_wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_ptr_q <= '0;
      res_rd_ptr_q <= '0;
      res_cnt_q    <= '0;
    end else begin
      if (p1_push) begin
        res_wr_ptr_q <= (res_wr_ptr_q == xpfec_pkg::RES_PTR_W'(xpfec_pkg::RES_DEPTH - 1))
                        ? '0 : res_wr_ptr_q + xpfec_pkg::RES_PTR_W'(1);
      end
      if (res_pop) begin
        res_rd_ptr_q <= (res_rd_ptr_q == xpfec_pkg::RES_PTR_W'(xpfec_pkg::RES_DEPTH - 1))
                        ? '0 : res_rd_ptr_q + xpfec_pkg::RES_PTR_W'(1);
      end
      res_cnt_q <= res_cnt_q + xpfec_pkg::RES_CNT_W'(p1_push)
                             - xpfec_pkg::RES_CNT_W'(res_pop);
    end
  end

  // Hold off input while the sweep runs or the queue could overflow.
  assign s_axis_tready_o = ~clr_busy_q &
    (({1'b0, res_cnt_q} + {2'b00, p1_push}) <= 3'(xpfec_pkg::RES_DEPTH - 1));

  assign m_axis_tvalid_o = (res_cnt_q != '0);
  assign m_axis_tuser_o  = res_head.kind;
  assign m_axis_tlast_o  = res_head.last;
  assign m_axis_tdata_o  = {2'b00,
                            res_head.pbyte,
                            16'(res_head.hdr.len),
                            res_head.hdr.ts,
                            res_head.hdr.m, res_head.hdr.pt,
                            res_head.hdr.p, res_head.hdr.x, res_head.hdr.cc,
                            res_head.offset_mask,
                            res_head.sn_base,
                            res_head.fec_seq};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `XPFEC_NEVER(a_clr_quiet, clr_busy_q && (p1_valid_q || fwd_valid_q))
  `XPFEC_ASSERT(a_read_idle, (in_acc && (s_axis_tuser_i == xpfec_pkg::OP_READ) && !draining_q) |=> !p1_valid_q)
  `XPFEC_ASSERT(a_drain_end, $fell(draining_q) |-> (p1_valid_q && (p1_res_q.kind == xpfec_pkg::KIND_BYTE) && p1_res_q.last))
  `XPFEC_ASSERT(a_largest_cap, largest_q <= STORE_LEN)
  `XPFEC_NEVER(a_queue_over, p1_push && (res_cnt_q == xpfec_pkg::RES_CNT_W'(xpfec_pkg::RES_DEPTH)) && !res_pop)

endmodule

`default_nettype wire
